[src/dnle_pkg.sv]
// Shared types and constants for the dotted name label encoder.
// No dependencies; used by dnle_cell and dotted_name_label_encoder.
`default_nettype none

package dnle_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
  localparam logic [CNT_W-1:0]  CNT_ZERO  = 6'd0;
  localparam logic [CNT_W-1:0]  CNT_ONE   = 6'd1;

  // Commands broadcast to every cell of the label chain.
  typedef struct packed {
    logic load;   // append the incoming character at the first empty cell
    logic shift;  // move every cell one step toward the head
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/dotted_name_label_encoder.sv]
// Top level of the dotted name label encoder: sequencer, output register
// and a chain of dnle_cell instances. Depends on dnle_pkg and dnle_cell.
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       request in in_valid/in_ready   in_char[7:0], in_name_last
// out_      result out out_valid/out_ready out_byte[7:0], out_run_last,
//                                          out_truncated
//
// A plain character that does not end the name is taken and produces nothing. A
// flush emits one result per cycle while out_ready allows: the length octet, each
// label byte shifted out of the head cell, then the empty final label and the
// terminator where they apply. Synchronous active-low reset clears the count, the
// overflow flag and the cell occupancy. A result held by a low out_ready freezes
// the flush; in_ready stays low until the flush is done.

module dotted_name_label_encoder #(
  parameter int LABEL_MAX = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dnle_pkg::BYTE_W-1:0]  in_char,
  input  wire logic                         in_name_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [dnle_pkg::BYTE_W-1:0]  out_byte,
  output logic                              out_run_last,
  output logic                              out_truncated
);

  localparam int CW = dnle_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(LABEL_MAX);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take characters
  localparam logic [2:0] ST_LEN   = 3'd1;  // emit the length octet
  localparam logic [2:0] ST_BYTES = 3'd2;  // shift out label bytes
  localparam logic [2:0] ST_EMPTY = 3'd3;  // emit the empty final label
  localparam logic [2:0] ST_TERM  = 3'd4;  // emit the zero terminator

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          pend_empty_r, pend_empty_nxt;
  logic          pend_term_r, pend_term_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [dnle_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_run_last_r, out_run_last_nxt;
  logic                        out_truncated_r, out_truncated_nxt;

  dnle_pkg::cell_ctl_t         cell_ctl;
  logic [dnle_pkg::BYTE_W-1:0] cell_byte [LABEL_MAX];
  logic                        cell_full [LABEL_MAX];

  logic       adv;
  logic [2:0] after_label;

  // ---------------------------------------------------------------------
  // Label chain: cell 0 is the head that feeds the output; new characters
  // land in the first empty cell, and each shift pulls every byte forward.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < LABEL_MAX; i++) begin : g_cell
    logic                        prev_full;
    logic [dnle_pkg::BYTE_W-1:0] next_byte;
    logic                        next_full;

    if (i == 0) begin : g_head
      assign prev_full = 1'b1;
    end else begin : g_body
      assign prev_full = cell_full[i-1];
    end

    if (i == LABEL_MAX - 1) begin : g_tail
      assign next_byte = dnle_pkg::ZERO_BYTE;
      assign next_full = 1'b0;
    end else begin : g_link
      assign next_byte = cell_byte[i+1];
      assign next_full = cell_full[i+1];
    end

    dnle_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .in_char   (in_char),
      .prev_full (prev_full),
      .next_byte (next_byte),
      .next_full (next_full),
      .byte_o    (cell_byte[i]),
      .full_o    (cell_full[i])
    );
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);

  // The output register can take a new result when empty or being drained.
  assign adv = !out_valid_r || out_ready;

  // Where to go once the label itself is out.
  assign after_label = pend_empty_r ? ST_EMPTY :
                       pend_term_r  ? ST_TERM  : ST_IDLE;

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    ovf_nxt           = ovf_r;
    pend_empty_nxt    = pend_empty_r;
    pend_term_nxt     = pend_term_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_byte_nxt      = out_byte_r;
    out_run_last_nxt  = out_run_last_r;
    out_truncated_nxt = out_truncated_r;
    cell_ctl.load     = 1'b0;
    cell_ctl.shift    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_char == dnle_pkg::DOT_CHAR) begin
            // Flush the label; a trailing dot adds an empty label.
            pend_empty_nxt = in_name_last;
            pend_term_nxt  = in_name_last;
            state_nxt      = ST_LEN;
          end else begin
            // Buffer the character, or drop it and mark the label cut.
            cell_ctl.load = 1'b1;
            if (cnt_r < MAX_CNT) begin
              cnt_nxt = cnt_r + dnle_pkg::CNT_ONE;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_name_last) begin
              pend_empty_nxt = 1'b0;
              pend_term_nxt  = 1'b1;
              state_nxt      = ST_LEN;
            end
          end
        end
      end
      ST_LEN: begin
        if (adv) begin
          out_valid_nxt     = 1'b1;
          out_byte_nxt      = dnle_pkg::BYTE_W'(cnt_r);
          out_truncated_nxt = ovf_r;
          out_run_last_nxt  = (cnt_r == dnle_pkg::CNT_ZERO) && !pend_term_r;
          if (cnt_r != dnle_pkg::CNT_ZERO) begin
            state_nxt = ST_BYTES;
          end else begin
            state_nxt = after_label;
            ovf_nxt   = 1'b0;
          end
        end
      end
      ST_BYTES: begin
        if (adv) begin
          out_valid_nxt     = 1'b1;
          out_byte_nxt      = cell_byte[0];
          out_truncated_nxt = ovf_r;
          out_run_last_nxt  = (cnt_r == dnle_pkg::CNT_ONE) && !pend_term_r;
          cell_ctl.shift    = 1'b1;
          cnt_nxt           = cnt_r - dnle_pkg::CNT_ONE;
          if (cnt_r == dnle_pkg::CNT_ONE) begin
            state_nxt = after_label;
            ovf_nxt   = 1'b0;
          end
        end
      end
      ST_EMPTY: begin
        if (adv) begin
          out_valid_nxt     = 1'b1;
          out_byte_nxt      = dnle_pkg::ZERO_BYTE;
          out_truncated_nxt = 1'b0;
          out_run_last_nxt  = 1'b0;
          state_nxt         = ST_TERM;
        end
      end
      ST_TERM: begin
        if (adv) begin
          out_valid_nxt     = 1'b1;
          out_byte_nxt      = dnle_pkg::ZERO_BYTE;
          out_truncated_nxt = 1'b0;
          out_run_last_nxt  = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= dnle_pkg::CNT_ZERO;
      ovf_r        <= 1'b0;
      pend_empty_r <= 1'b0;
      pend_term_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      pend_empty_r <= pend_empty_nxt;
      pend_term_r  <= pend_term_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output payload: held while a result waits
  always_ff @(posedge clk) begin
    out_byte_r      <= out_byte_nxt;
    out_run_last_r  <= out_run_last_nxt;
    out_truncated_r <= out_truncated_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_truncated = out_truncated_r;

`ifndef SYNTH
  // The count never runs past the chain length.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("label count above LABEL_MAX");

  // Head cell occupancy tracks a nonzero count.
  a_head_full: assert property (@(posedge clk) disable iff (!rst_n)
    cell_full[0] == (cnt_r != dnle_pkg::CNT_ZERO))
    else $error("chain occupancy out of step with label count");

  // A name-ending request always starts a flush.
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_name_last |=> !in_ready)
    else $error("last character did not start a flush");
`endif

endmodule

`default_nettype wire

[src/dnle_cell.sv]
// One cell of the label chain: one buffered byte and its occupancy bit.
// Depends on dnle_pkg.
`default_nettype none

module dnle_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dnle_pkg::cell_ctl_t          ctl,
  input  wire logic [dnle_pkg::BYTE_W-1:0]  in_char,
  input  wire logic                         prev_full,
  input  wire logic [dnle_pkg::BYTE_W-1:0]  next_byte,
  input  wire logic                         next_full,
  output logic      [dnle_pkg::BYTE_W-1:0]  byte_o,
  output logic                              full_o
);

  logic [dnle_pkg::BYTE_W-1:0] byte_r;
  logic                        full_r;

  // Occupancy is control state; the byte is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (ctl.shift) begin
      full_r <= next_full;
    end else if (ctl.load && prev_full && !full_r) begin
      full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= next_byte;
    end else if (ctl.load && prev_full && !full_r) begin
      byte_r <= in_char;
    end
  end

  assign byte_o = byte_r;
  assign full_o = full_r;

endmodule

`default_nettype wire
